[design/swk_pkg.sv]
// Package for the swerve wheel kinematics core: widths, register indexes,
// CORDIC angle constants. Used by swk_vector and swerve_wheel_kinematics_core.
package swk_pkg;

	localparam int OPD_W   = 20;  // wheel vector component, signed
	localparam int SQ_W    = 38;  // sum of squares, unsigned
	localparam int MAG_W   = 19;  // wheel vector magnitude, unsigned
	localparam int CW      = 42;  // CORDIC x/y datapath, signed
	localparam int Z_W     = 27;  // CORDIC angle accumulator, signed
	localparam int STEPS   = 18;  // CORDIC iterations
	localparam int PRESCALE = 20;
	localparam int SQRT_STEPS = 19;
	localparam int QUO_W   = 16;  // normalized speed
	localparam int DIV_W   = 34;  // magnitude scaled by full speed

	localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(18432000);
	localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(512);
	localparam logic signed [16:0] ANGLE_MAX = 17'sd18000;
	localparam logic signed [16:0] ANGLE_MIN = -17'sd18000;
	localparam logic [MAG_W-1:0] FULL_SPEED = MAG_W'(32768);

	localparam logic [1:0] REG_WHEEL_BASE  = 2'd0;
	localparam logic [1:0] REG_TRACK_WIDTH = 2'd1;
	localparam logic [15:0] GEOMETRY_RESET = 16'd4096;

	function automatic logic signed [Z_W-1:0] atan_coef(input int i);
		logic signed [Z_W-1:0] c;
		unique case (i)
			0:  c = Z_W'(4608000);
			1:  c = Z_W'(2720261);
			2:  c = Z_W'(1437311);
			3:  c = Z_W'(729602);
			4:  c = Z_W'(366217);
			5:  c = Z_W'(183287);
			6:  c = Z_W'(91666);
			7:  c = Z_W'(45836);
			8:  c = Z_W'(22918);
			9:  c = Z_W'(11459);
			10: c = Z_W'(5730);
			11: c = Z_W'(2865);
			12: c = Z_W'(1432);
			13: c = Z_W'(716);
			14: c = Z_W'(358);
			15: c = Z_W'(179);
			16: c = Z_W'(90);
			17: c = Z_W'(45);
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

[design/swk_vector.sv]
// Per-wheel vector unit: pipelined CORDIC angle and pipelined integer sqrt
// magnitude, both leaving the pipeline together. Depends on swk_pkg.
module swk_vector (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [swk_pkg::OPD_W-1:0]   p,
	input  logic signed [swk_pkg::OPD_W-1:0]   q,
	output logic                               out_valid,
	output logic signed [15:0]                 angle,
	output logic [swk_pkg::MAG_W-1:0]          mag
);

	localparam int CW    = swk_pkg::CW;
	localparam int Z_W   = swk_pkg::Z_W;
	localparam int STEPS = swk_pkg::STEPS;
	localparam int NS    = swk_pkg::SQRT_STEPS;
	localparam int SQ_W  = swk_pkg::SQ_W;
	localparam int LAT   = 21;

	logic [LAT:1] valid_s;

	// stage 1: squares and CORDIC pre-rotation
	logic [SQ_W-2:0] sq_p_s1, sq_q_s1;
	logic signed [2*swk_pkg::OPD_W-1:0] pp, qq;
	logic signed [CW-1:0] p_ext, q_ext;

	logic signed [CW-1:0]  cx [0:STEPS];
	logic signed [CW-1:0]  cy [0:STEPS];
	logic signed [Z_W-1:0] cz [0:STEPS];
	logic                  zero_f [0:STEPS];
	logic                  neg_f [0:STEPS];

	assign pp = p * p;
	assign qq = q * q;
	assign p_ext = CW'(p) <<< swk_pkg::PRESCALE;
	assign q_ext = CW'(q) <<< swk_pkg::PRESCALE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[LAT-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		sq_p_s1   <= pp[SQ_W-2:0];
		sq_q_s1   <= qq[SQ_W-2:0];
		zero_f[0] <= (p == '0);
		neg_f[0]  <= q[swk_pkg::OPD_W-1];
		if (q[swk_pkg::OPD_W-1]) begin
			cx[0] <= -q_ext;
			cy[0] <= -p_ext;
			cz[0] <= (p > 0) ? swk_pkg::HALF_TURN : -swk_pkg::HALF_TURN;
		end else begin
			cx[0] <= q_ext;
			cy[0] <= p_ext;
			cz[0] <= '0;
		end
	end

	// CORDIC steps: step i at stage i+2
	for (genvar i = 0; i < STEPS; i++) begin : g_cordic
		logic signed [CW-1:0] dx, dy;
		assign dx = cy[i] >>> i;
		assign dy = cx[i] >>> i;
		always_ff @(posedge clk) begin
			zero_f[i+1] <= zero_f[i];
			neg_f[i+1]  <= neg_f[i];
			if (cy[i] > 0) begin
				cx[i+1] <= cx[i] + dx;
				cy[i+1] <= cy[i] - dy;
				cz[i+1] <= cz[i] + swk_pkg::atan_coef(i);
			end else begin
				cx[i+1] <= cx[i] - dx;
				cy[i+1] <= cy[i] + dy;
				cz[i+1] <= cz[i] - swk_pkg::atan_coef(i);
			end
		end
	end

	// stage 20 round, stage 21 clamp
	logic signed [Z_W-1:0] z_bias;
	logic signed [16:0]    rnd_s20;
	logic                  zero_s20, neg_s20;
	logic signed [15:0]    ang_s21;

	assign z_bias = (cz[STEPS] + swk_pkg::ROUND_HALF) >>> 10;

	always_ff @(posedge clk) begin
		rnd_s20  <= z_bias[16:0];
		zero_s20 <= zero_f[STEPS];
		neg_s20  <= neg_f[STEPS];
		priority if (zero_s20) begin
			ang_s21 <= neg_s20 ? 16'(swk_pkg::ANGLE_MAX) : '0;
		end else if (rnd_s20 > swk_pkg::ANGLE_MAX) begin
			ang_s21 <= 16'(swk_pkg::ANGLE_MAX);
		end else if (rnd_s20 < swk_pkg::ANGLE_MIN) begin
			ang_s21 <= 16'(swk_pkg::ANGLE_MIN);
		end else begin
			ang_s21 <= rnd_s20[15:0];
		end
	end

	// magnitude: sum at stage 2, one root digit per stage 3..21
	logic [SQ_W-1:0] rem_s [0:NS];
	logic [SQ_W-1:0] root_s [0:NS];

	always_ff @(posedge clk) begin
		rem_s[0]  <= {1'b0, sq_p_s1} + {1'b0, sq_q_s1};
		root_s[0] <= '0;
	end

	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (NS - 1 - k));
		logic [SQ_W-1:0] trial;
		assign trial = root_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (rem_s[k] >= trial) begin
				rem_s[k+1]  <= rem_s[k] - trial;
				root_s[k+1] <= (root_s[k] >> 1) + BIT;
			end else begin
				rem_s[k+1]  <= rem_s[k];
				root_s[k+1] <= root_s[k] >> 1;
			end
		end
	end

	assign out_valid = valid_s[LAT];
	assign angle     = ang_s21;
	assign mag       = root_s[NS][swk_pkg::MAG_W-1:0];

endmodule

[design/swerve_wheel_kinematics_core.sv]
// Top level of the swerve wheel kinematics core: geometry registers, wheel
// vectors, normalization divider. Depends on swk_pkg and swk_vector.
//
// One drive command is taken on every clock cycle (busy is never raised) and
// its eight wheel outputs appear with a one-cycle done strobe; the path runs
// through the 21-stage wheel vector unit (18 CORDIC steps, 19 square-root
// digits) and the 16-stage restoring divider of the speed normalization.
// Results cannot be held off by the receiver. Geometry registers are written
// through the cfg channel (always ready); the user must write them only while
// no command is in flight, as the block itself does not enforce it.
module swerve_wheel_kinematics_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] strafe_speed,
	input  logic signed [15:0] forward_speed,
	input  logic signed [15:0] rotation_rate,
	output logic               done,
	output logic signed [15:0] front_left_angle,
	output logic signed [15:0] front_right_angle,
	output logic signed [15:0] back_left_angle,
	output logic signed [15:0] back_right_angle,
	output logic [15:0]        front_left_speed,
	output logic [15:0]        front_right_speed,
	output logic [15:0]        back_left_speed,
	output logic [15:0]        back_right_speed,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int OPD_W = swk_pkg::OPD_W;
	localparam int MAG_W = swk_pkg::MAG_W;
	localparam int QUO_W = swk_pkg::QUO_W;
	localparam int DIV_W = swk_pkg::DIV_W;

	logic [15:0] wheel_base_q, track_width_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_base_q  <= swk_pkg::GEOMETRY_RESET;
			track_width_q <= swk_pkg::GEOMETRY_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == swk_pkg::REG_WHEEL_BASE) begin
				wheel_base_q <= cfg_data;
			end
			if (cfg_index == swk_pkg::REG_TRACK_WIDTH) begin
				track_width_q <= cfg_data;
			end
		end
	end

	// s1: rotation products
	logic signed [32:0] prod_wb, prod_tw;
	logic signed [31:0] prod_wb_s1, prod_tw_s1;
	logic signed [15:0] x_s1, y_s1;
	logic               valid_s1;

	assign prod_wb = rotation_rate * $signed({1'b0, wheel_base_q});
	assign prod_tw = rotation_rate * $signed({1'b0, track_width_q});

	always_ff @(posedge clk) begin
		prod_wb_s1 <= prod_wb[31:0];
		prod_tw_s1 <= prod_tw[31:0];
		x_s1       <= strafe_speed;
		y_s1       <= forward_speed;
	end

	// s2: wheel vector components
	logic signed [31:0]      tw_full, tt_full;
	logic signed [OPD_W-1:0] tw, tt, x_e, y_e;
	logic signed [OPD_W-1:0] a_s2, b_s2, c_s2, d_s2;
	logic                    valid_s2;

	assign tw_full = prod_wb_s1 >>> 13;
	assign tt_full = prod_tw_s1 >>> 13;
	assign tw  = tw_full[OPD_W-1:0];
	assign tt  = tt_full[OPD_W-1:0];
	assign x_e = OPD_W'(x_s1);
	assign y_e = OPD_W'(y_s1);

	always_ff @(posedge clk) begin
		a_s2 <= x_e - tw;
		b_s2 <= x_e + tw;
		c_s2 <= y_e - tt;
		d_s2 <= y_e + tt;
	end

	// s3..s23: per-wheel angle and magnitude (order FL, FR, BL, BR)
	logic signed [OPD_W-1:0] vp [0:3];
	logic signed [OPD_W-1:0] vq [0:3];
	logic                    vec_valid [0:3];
	logic signed [15:0]      ang_s23 [0:3];
	logic [MAG_W-1:0]        mag_s23 [0:3];

	assign vp[0] = a_s2; assign vq[0] = c_s2;
	assign vp[1] = a_s2; assign vq[1] = d_s2;
	assign vp[2] = b_s2; assign vq[2] = c_s2;
	assign vp[3] = b_s2; assign vq[3] = d_s2;

	for (genvar w = 0; w < 4; w++) begin : g_wheel
		swk_vector u_vec (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_s2),
			.p         (vp[w]),
			.q         (vq[w]),
			.out_valid (vec_valid[w]),
			.angle     (ang_s23[w]),
			.mag       (mag_s23[w])
		);
	end

	// s24, s25: largest magnitude
	logic [MAG_W-1:0]   mab_s24, mcd_s24, mx_s25;
	logic [MAG_W-1:0]   m_s24 [0:3];
	logic [MAG_W-1:0]   m_s25 [0:3];
	logic signed [15:0] ang_s24 [0:3];
	logic signed [15:0] ang_s25 [0:3];
	logic               norm_s25, valid_s24, valid_s25;

	always_ff @(posedge clk) begin
		mab_s24 <= (mag_s23[0] > mag_s23[1]) ? mag_s23[0] : mag_s23[1];
		mcd_s24 <= (mag_s23[2] > mag_s23[3]) ? mag_s23[2] : mag_s23[3];
		mx_s25  <= (mab_s24 > mcd_s24) ? mab_s24 : mcd_s24;
		norm_s25 <= ((mab_s24 > mcd_s24) ? mab_s24 : mcd_s24) > swk_pkg::FULL_SPEED;
		for (int w = 0; w < 4; w++) begin
			m_s24[w]   <= mag_s23[w];
			ang_s24[w] <= ang_s23[w];
			m_s25[w]   <= m_s24[w];
			ang_s25[w] <= ang_s24[w];
		end
	end

	// s26..s41: restoring divide m * 32768 / max, one quotient bit per stage
	logic [DIV_W-1:0]   dv_rem [0:15][0:3];
	logic [QUO_W-1:0]   dv_quo [0:15][0:3];
	logic [QUO_W-1:0]   dv_m   [0:15][0:3];
	logic signed [15:0] dv_ang [0:15][0:3];
	logic [MAG_W-1:0]   dv_mx  [0:15];
	logic               dv_norm [0:15];
	logic [DIV_W-1:0]   dv_start [0:3];

	for (genvar w = 0; w < 4; w++) begin : g_dstart
		assign dv_start[w] = DIV_W'(m_s25[w]) << 15;
	end

	for (genvar j = 0; j < 16; j++) begin : g_div
		localparam int K = 15 - j;
		logic [DIV_W-1:0] rem_in [0:3];
		logic [QUO_W-1:0] quo_in [0:3];
		logic [MAG_W-1:0] mx_in;
		logic [DIV_W-1:0] dsh;
		if (j == 0) begin : g_first
			for (genvar w = 0; w < 4; w++) begin : g_l
				assign rem_in[w] = dv_start[w];
				assign quo_in[w] = '0;
			end
			assign mx_in = mx_s25;
			always_ff @(posedge clk) begin
				dv_norm[j] <= norm_s25;
				for (int w = 0; w < 4; w++) begin
					dv_m[j][w]   <= m_s25[w][QUO_W-1:0];
					dv_ang[j][w] <= ang_s25[w];
				end
			end
		end else begin : g_next
			for (genvar w = 0; w < 4; w++) begin : g_l
				assign rem_in[w] = dv_rem[j-1][w];
				assign quo_in[w] = dv_quo[j-1][w];
			end
			assign mx_in = dv_mx[j-1];
			always_ff @(posedge clk) begin
				dv_norm[j] <= dv_norm[j-1];
				for (int w = 0; w < 4; w++) begin
					dv_m[j][w]   <= dv_m[j-1][w];
					dv_ang[j][w] <= dv_ang[j-1][w];
				end
			end
		end
		assign dsh = DIV_W'(mx_in) << K;
		always_ff @(posedge clk) begin
			dv_mx[j] <= mx_in;
			for (int w = 0; w < 4; w++) begin
				if (rem_in[w] >= dsh) begin
					dv_rem[j][w] <= rem_in[w] - dsh;
					dv_quo[j][w] <= quo_in[w] | (QUO_W'(1) << K);
				end else begin
					dv_rem[j][w] <= rem_in[w];
					dv_quo[j][w] <= quo_in[w];
				end
			end
		end
	end

	// s42: result registers
	logic [15:0]        spd_s42 [0:3];
	logic signed [15:0] ang_s42 [0:3];
	logic [16:1]        valid_sh;

	always_ff @(posedge clk) begin
		for (int w = 0; w < 4; w++) begin
			spd_s42[w] <= dv_norm[15] ? dv_quo[15][w] : dv_m[15][w];
			ang_s42[w] <= dv_ang[15][w];
		end
	end

	// valid bits travel alongside the data; the wheel units track s3..s23
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s24 <= 1'b0;
			valid_s25 <= 1'b0;
			valid_sh  <= '0;
			done      <= 1'b0;
		end else begin
			valid_s1  <= start && !busy;
			valid_s2  <= valid_s1;
			valid_s24 <= vec_valid[0];
			valid_s25 <= valid_s24;
			valid_sh  <= {valid_sh[15:1], valid_s25};
			done      <= valid_sh[16];
		end
	end

	assign front_left_angle  = ang_s42[0];
	assign front_right_angle = ang_s42[1];
	assign back_left_angle   = ang_s42[2];
	assign back_right_angle  = ang_s42[3];
	assign front_left_speed  = spd_s42[0];
	assign front_right_speed = spd_s42[1];
	assign back_left_speed   = spd_s42[2];
	assign back_right_speed  = spd_s42[3];

endmodule
